// ===== rtl/core/trd_pkg.sv =====
// Shared types and constants of the touch report decoder.
package trd_pkg;

	localparam int BUFFER_BYTES_DEF = 32;
	localparam int SLOT_LIMIT_DEF   = 10;

	localparam logic [11:0] MASK_BITS   = 12'h3FF;
	localparam logic [11:0] HIGH_NIBBLE = 12'hF00;

	localparam logic [3:0] FINGER_COUNT_RST = 4'd10;

	typedef enum logic [1:0] {
		CFG_FINGER_COUNT = 2'd0,
		CFG_ID_OFFSET_EN = 2'd1,
		CFG_ID_BASE      = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_CONTACT   = 2'd0,
		EV_LIFT      = 2'd1,
		EV_FRAME_END = 2'd2
	} ev_kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SLOT,
		B_RX,
		B_RY,
		B_CT,
		B_END
	} back_state_t;

	typedef struct packed {
		logic [3:0] finger_count;
		logic       id_offset_enable;
		logic [9:0] id_base;
	} cfg_t;

	typedef struct packed {
		ev_kind_t    event_kind;
		logic [10:0] tracking_id;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic        last_result;
	} result_t;

endpackage

// ===== rtl/core/trd_front.sv =====
// Front end: byte intake, double-banked packet buffer, request building.
module trd_front import trd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int SLOT_LIMIT   = SLOT_LIMIT_DEF,
	localparam int OFFS_W = $clog2(BUFFER_BYTES),
	localparam int LEN_W  = OFFS_W + 1,
	localparam int ADDR_W = OFFS_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output logic                  push,
	output logic [SLOT_LIMIT-1:0] job_mask,
	output logic [LEN_W-1:0]      job_len,
	input  logic                  done,
	input  logic [ADDR_W-1:0]     rd_addr,
	output logic [7:0]            rd_data
);

	logic [7:0]       mem [0:(1 << ADDR_W)-1];
	logic [7:0]       rd_data_q;
	logic [LEN_W-1:0] len_q, len_n;
	logic             ovf_q, ovf_n;
	logic [7:0]       b0_q, b1_q, b0_n, b1_n;
	logic             wbank_q;
	logic [1:0]       pend_q;
	logic             acc, store;
	logic [11:0]      mask12;

	assign in_ready = (pend_q != 2'd2);
	assign acc      = in_valid && in_ready;
	assign store    = (len_q < LEN_W'(BUFFER_BYTES));

	always_comb begin
		b0_n  = b0_q;
		b1_n  = b1_q;
		len_n = len_q;
		if (acc && store) begin
			len_n = len_q + LEN_W'(1);
			if (len_q == LEN_W'(0))
				b0_n = in_byte;
			if (len_q == LEN_W'(1))
				b1_n = in_byte;
		end
		ovf_n    = ovf_q || (acc && !store);
		push     = acc && in_last && !ovf_n;
		mask12   = ({b1_n, 4'h0} | {4'h0, b0_n}) & MASK_BITS;
		job_mask = mask12[SLOT_LIMIT-1:0];
		job_len  = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			b0_q    <= '0;
			b1_q    <= '0;
			wbank_q <= 1'b0;
			pend_q  <= '0;
		end else begin
			if (acc && in_last) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				b0_q  <= '0;
				b1_q  <= '0;
			end else begin
				len_q <= len_n;
				ovf_q <= ovf_n;
				b0_q  <= b0_n;
				b1_q  <= b1_n;
			end
			if (push)
				wbank_q <= ~wbank_q;
			if (push && !done)
				pend_q <= pend_q + 2'd1;
			else if (!push && done)
				pend_q <= pend_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && store)
			mem[{wbank_q, len_q[OFFS_W-1:0]}] <= in_byte;
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/trd_jobq.sv =====
// Two-entry request queue between front and back.
module trd_jobq #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty
);

	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_data;
	end

endmodule

// ===== rtl/core/trd_back.sv =====
// Back end: walks finger slots of one request and issues result items.
module trd_back import trd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int SLOT_LIMIT   = SLOT_LIMIT_DEF,
	localparam int OFFS_W = $clog2(BUFFER_BYTES),
	localparam int LEN_W  = OFFS_W + 1,
	localparam int ADDR_W = OFFS_W + 1,
	localparam int SLOT_W = $clog2(SLOT_LIMIT + 1),
	localparam int IDX_W  = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        q_empty,
	input  logic [SLOT_LIMIT+LEN_W-1:0] q_head,
	output logic                        pop,
	output logic                        done,
	output logic [ADDR_W-1:0]           rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        ev_valid,
	input  logic                        ev_ready,
	output result_t                     ev
);

	back_state_t           st_q, st_d;
	logic [SLOT_LIMIT-1:0] mask_q, down_q;
	logic [LEN_W-1:0]      len_q;
	logic [SLOT_W-1:0]     i_q;
	logic [OFFS_W-1:0]     rec_q, rd_off;
	logic                  rbank_q, ok_q;
	logic [7:0]            hi_q, xlo_q, rbyte;
	logic [3:0]            cnt;
	logic [IDX_W-1:0]      idx;
	logic [10:0]           id;
	logic                  adv, set_down, clr_down;

	assign cnt   = (cfg.finger_count > 4'(SLOT_LIMIT)) ? 4'(SLOT_LIMIT) : cfg.finger_count;
	assign idx   = i_q[IDX_W-1:0];
	assign id    = cfg.id_offset_enable ? (11'(cfg.id_base) + 11'(i_q)) : 11'(i_q);
	assign rbyte = ok_q ? rd_data : 8'h00;
	assign rd_addr = {rbank_q, rd_off};

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		done     = 1'b0;
		ev_valid = 1'b0;
		ev       = '0;
		rd_off   = rec_q;
		adv      = 1'b0;
		set_down = 1'b0;
		clr_down = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop  = 1'b1;
					st_d = B_SLOT;
				end
			end
			B_SLOT: begin
				if (4'(i_q) >= cnt) begin
					st_d = B_END;
				end else if (mask_q[idx]) begin
					st_d = B_RX;
				end else if (down_q[idx]) begin
					ev_valid       = 1'b1;
					ev.event_kind  = EV_LIFT;
					ev.tracking_id = id;
					if (ev_ready) begin
						clr_down = 1'b1;
						adv      = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
			end
			B_RX: begin
				rd_off = rec_q + OFFS_W'(1);
				st_d   = B_RY;
			end
			B_RY: begin
				rd_off = rec_q + OFFS_W'(2);
				st_d   = B_CT;
			end
			B_CT: begin
				rd_off         = rec_q + OFFS_W'(2);
				ev_valid       = 1'b1;
				ev.event_kind  = EV_CONTACT;
				ev.tracking_id = id;
				ev.pos_x       = ({hi_q, 4'h0} & HIGH_NIBBLE) | {4'h0, xlo_q};
				ev.pos_y       = (12'({hi_q, 8'h00}) & HIGH_NIBBLE) | {4'h0, rbyte};
				if (ev_ready) begin
					set_down = 1'b1;
					adv      = 1'b1;
					st_d     = B_SLOT;
				end
			end
			B_END: begin
				ev_valid       = 1'b1;
				ev.event_kind  = EV_FRAME_END;
				ev.last_result = 1'b1;
				if (ev_ready) begin
					done = 1'b1;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			down_q  <= '0;
			rbank_q <= 1'b0;
			i_q     <= '0;
		end else begin
			st_q <= st_d;
			if (pop)
				i_q <= '0;
			else if (adv)
				i_q <= i_q + SLOT_W'(1);
			if (set_down)
				down_q[idx] <= 1'b1;
			if (clr_down)
				down_q[idx] <= 1'b0;
			if (done)
				rbank_q <= ~rbank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q <= q_head[SLOT_LIMIT+LEN_W-1:LEN_W];
			len_q  <= q_head[LEN_W-1:0];
			rec_q  <= OFFS_W'(2);
		end else if (set_down) begin
			rec_q <= rec_q + OFFS_W'(3);
		end
		ok_q <= ({1'b0, rd_off} < len_q);
		if (st_q == B_RX)
			hi_q <= rbyte;
		if (st_q == B_RY)
			xlo_q <= rbyte;
	end

endmodule

// ===== rtl/core/touch_report_decoder.sv =====
// Top level of the touch report decoder.
//
// Report bytes enter on the s_ stream, one per request, s_tlast on the
// final byte. Non-final bytes produce nothing. The final byte hands the
// packet to the slot walker, which emits on the m_ stream one contact or
// lifted-slot item per affected slot, then a frame-end item with m_tlast.
// An overlong packet is dropped with no output.
// A byte is taken whenever s_tvalid and s_tready are both high. The final
// byte's request passes through the request queue to the idle walker. Each
// contact walks B_SLOT, B_RX, B_RY and B_CT (three reads of the packet
// buffer), each lifted or idle slot B_SLOT only, and the frame end B_END.
// The buffer has two banks, so the next packet is taken while the previous
// one drains; s_tready drops only while two packets wait.
// A stalled m_tready holds the output register and the walker; bytes keep
// arriving until both banks are taken.
// Reset clears all counters, the finger-down bits and the registers
// (finger_count 10, offset off, id_base 0). Configure only while idle.
module touch_report_decoder import trd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int SLOT_LIMIT   = SLOT_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tracking_id, pos_x, pos_y, zero pad
	output logic [1:0]  m_tuser,   // event_kind
	output logic        m_tlast,   // last_result
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int OFFS_W = $clog2(BUFFER_BYTES);
	localparam int LEN_W  = OFFS_W + 1;
	localparam int ADDR_W = OFFS_W + 1;
	localparam int JOB_W  = SLOT_LIMIT + LEN_W;

	cfg_t                  cfg_q;
	logic                  push, pop, done, q_empty;
	logic [SLOT_LIMIT-1:0] job_mask;
	logic [LEN_W-1:0]      job_len;
	logic [JOB_W-1:0]      q_head;
	logic [ADDR_W-1:0]     rd_addr;
	logic [7:0]            rd_data;
	logic                  ev_valid, ev_ready;
	result_t               ev;
	logic                  m_tvalid_q;
	result_t               out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finger_count     <= FINGER_COUNT_RST;
			cfg_q.id_offset_enable <= 1'b0;
			cfg_q.id_base          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FINGER_COUNT: cfg_q.finger_count     <= cfg_data[3:0];
				CFG_ID_OFFSET_EN: cfg_q.id_offset_enable <= cfg_data[0];
				CFG_ID_BASE:      cfg_q.id_base          <= cfg_data;
				default: ;
			endcase
		end
	end

	trd_front #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.SLOT_LIMIT  (SLOT_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.job_mask (job_mask),
		.job_len  (job_len),
		.done     (done),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	trd_jobq #(
		.W(JOB_W)
	) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({job_mask, job_len}),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	trd_back #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.SLOT_LIMIT  (SLOT_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.done     (done),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.ev_valid (ev_valid),
		.ev_ready (ev_ready),
		.ev       (ev)
	);

	assign ev_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ev_ready)
			m_tvalid_q <= ev_valid;
	end

	always_ff @(posedge clk) begin
		if (ev_ready && ev_valid)
			out_q <= ev;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_q.pos_y, out_q.pos_x, out_q.tracking_id};
	assign m_tuser  = out_q.event_kind;
	assign m_tlast  = out_q.last_result;

endmodule

// ===== tb/sv/touch_event_checker.sv =====
// Decoder event checker: follows the report bytes and register writes, predicts events, compares.
module touch_event_checker import trd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // tracking_id, pos_x, pos_y, zero pad
	input  logic [1:0]  m_tuser,   // event_kind
	input  logic        m_tlast,   // last_result
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam int STORE_BYTES = BUFFER_BYTES_DEF;
	localparam int SLOTS       = SLOT_LIMIT_DEF;

	logic [7:0]       report_bytes [STORE_BYTES];
	int               byte_count;
	logic             packet_too_long;
	logic [SLOTS-1:0] finger_is_down;
	cfg_t             shadow_cfg;
	result_t          expected_events [$];

	task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
		if (mismatches < 200)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic restart_packet();
		foreach (report_bytes[i])
			report_bytes[i] = 8'h00;
		byte_count = 0;
		packet_too_long = 1'b0;
	endtask

	task automatic take_report_byte(input logic [7:0] data, input logic last);
		int          slots;
		int          rec;
		int          used;
		logic [11:0] mask;
		logic [7:0]  hi;
		result_t     ev;
		if (byte_count < STORE_BYTES) begin
			report_bytes[byte_count] = data;
			byte_count++;
		end else
			packet_too_long = 1'b1;
		if (!last)
			return;
		if (!packet_too_long) begin
			slots = (shadow_cfg.finger_count > SLOTS) ? SLOTS : int'(shadow_cfg.finger_count);
			mask = ({report_bytes[1], 4'h0} | {4'h0, report_bytes[0]}) & MASK_BITS;
			used = 0;
			for (int i = 0; i < slots; i++) begin
				ev = '0;
				ev.tracking_id = shadow_cfg.id_offset_enable ?
					11'(shadow_cfg.id_base) + 11'(i) : 11'(i);
				if (mask[i]) begin
					rec = 2 + 3 * used;
					hi = report_bytes[rec];
					ev.event_kind = EV_CONTACT;
					ev.pos_x = {hi[7:4], report_bytes[rec + 1]};
					ev.pos_y = {hi[3:0], report_bytes[rec + 2]};
					finger_is_down[i] = 1'b1;
					used++;
					expected_events.push_back(ev);
				end else if (finger_is_down[i]) begin
					ev.event_kind = EV_LIFT;
					finger_is_down[i] = 1'b0;
					expected_events.push_back(ev);
				end
			end
			ev = '0;
			ev.event_kind = EV_FRAME_END;
			ev.last_result = 1'b1;
			expected_events.push_back(ev);
		end
		restart_packet();
	endtask

	task automatic check_event();
		result_t want;
		if (expected_events.size() == 0) begin
			report("event with none expected", {m_tuser, m_tdata[37:0]}, '0);
			return;
		end
		want = expected_events.pop_front();
		if (m_tuser !== want.event_kind)
			report("event_kind", m_tuser, want.event_kind);
		if (m_tdata[10:0] !== want.tracking_id)
			report("tracking_id", m_tdata[10:0], want.tracking_id);
		if (m_tdata[22:11] !== want.pos_x)
			report("pos_x", m_tdata[22:11], want.pos_x);
		if (m_tdata[34:23] !== want.pos_y)
			report("pos_y", m_tdata[34:23], want.pos_y);
		if (m_tdata[39:35] !== 5'd0)
			report("tdata padding", m_tdata[39:35], '0);
		if (m_tlast !== want.last_result)
			report("last_result", m_tlast, want.last_result);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_packet();
			finger_is_down = '0;
			shadow_cfg = '{finger_count: FINGER_COUNT_RST, id_offset_enable: 1'b0,
				id_base: 10'd0};
			expected_events.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FINGER_COUNT: shadow_cfg.finger_count = cfg_data[3:0];
					CFG_ID_OFFSET_EN: shadow_cfg.id_offset_enable = cfg_data[0];
					CFG_ID_BASE:      shadow_cfg.id_base = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_event();
			if (s_tvalid && s_tready)
				take_report_byte(s_tdata, s_tlast);
			pending <= expected_events.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Bench top for the touch report decoder: clock, reset, report stimulus, pacing and verdict.
module testbench;
	import trd_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3; // no register behind this index
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 60;   // quiet time after the checker has no events pending
	localparam int STALL_LIMIT   = 3000;

	typedef logic [7:0] byte_q_t [$];
	typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_BEAT} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;
	int          mismatches;
	int          pending;

	int          burst_left;
	logic        sender_calm;
	logic        rx_hold;
	logic [3:0]  cur_fingers;

	touch_report_decoder DUT (.*);

	touch_event_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_byte(input logic [7:0] data, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_calm ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic send_packet(input byte_q_t pkt);
		foreach (pkt[i])
			push_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_fingers(input logic [9:0] value);
		write_reg(CFG_FINGER_COUNT, value);
		cur_fingers = value[3:0];
	endtask

	// stop offering, wait out every pending event, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic make_packet(output byte_q_t pkt);
		int         kind;
		int         fingers;
		int         records;
		int         len;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [9:0] mask;
		pkt = {};
		kind = $urandom_range(0, 99);
		fingers = (cur_fingers > SLOT_LIMIT_DEF) ? SLOT_LIMIT_DEF : int'(cur_fingers);
		b0 = 8'($urandom);
		b1 = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
		mask = 10'({b1, 4'h0} | {4'h0, b0});
		records = 0;
		for (int i = 0; i < fingers; i++)
			if (mask[i])
				records++;
		len = 2 + 3 * records;
		if (kind < 8)
			len = $urandom_range(33, 40);
		else if (kind < 16)
			len = $urandom_range(1, len);
		else if (kind < 24)
			len = $urandom_range(len, 32);
		pkt.push_back(b0);
		if (len >= 2)
			pkt.push_back(b1);
		while (pkt.size() < len)
			pkt.push_back(8'($urandom));
	endtask

	task automatic random_phase(input int byte_budget);
		byte_q_t pkt;
		int      sent;
		sent = 0;
		while (sent < byte_budget) begin
			make_packet(pkt);
			send_packet(pkt);
			sent += pkt.size();
		end
	endtask

	// receiver pacing
	initial begin
		rx_mode_t mode;
		int       window;
		int       tick;
		bit       held;
		m_tready = 1'b0;
		mode = RX_ALWAYS;
		window = 0;
		tick = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold && !held) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
				m_tready <= 1'b1;
			end else begin
				if (window == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					window = $urandom_range(20, 80);
				end
				window--;
				tick++;
				case (mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
					RX_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no request moving anywhere
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		byte_q_t pkt;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_hold = 1'b0;
		sender_calm = 1'b0;
		burst_left = 0;
		cur_fingers = FINGER_COUNT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short packets, empty mask, top mask bits, coordinate extremes
		pkt = '{8'hFF};
		send_packet(pkt);
		pkt = '{8'h00, 8'h00};
		send_packet(pkt);
		pkt = '{8'h00, 8'hFF};
		send_packet(pkt);
		pkt = '{8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		send_packet(pkt);
		pkt = '{8'h00, 8'h20, 8'hA5, 8'h3C, 8'hC3};
		send_packet(pkt);
		settle();
		write_reg(CFG_ID_OFFSET_EN, 10'd1);
		write_reg(CFG_ID_BASE, 10'd1023);
		pkt = '{8'hFF, 8'hFF};
		send_packet(pkt);
		settle();
		set_fingers(10'd0);
		write_reg(CFG_SPARE, 10'h2AA);
		pkt = '{8'h55, 8'hAA};
		send_packet(pkt);
		settle();

		// random: default slots, starting with an overlong packet
		set_fingers(10'd10);
		write_reg(CFG_ID_OFFSET_EN, 10'd0);
		pkt = {};
		repeat (36) pkt.push_back(8'($urandom));
		send_packet(pkt);
		random_phase(55);
		settle();

		// receiver holds off while the sender keeps offering
		set_fingers({6'($urandom), 4'($urandom_range(1, 9))});
		write_reg(CFG_ID_OFFSET_EN, {9'($urandom), 1'b1});
		write_reg(CFG_ID_BASE, 10'($urandom));
		sender_calm = 1'b1;
		rx_hold <= 1'b1;
		random_phase(65);
		settle();

		// count above the slot limit saturates
		sender_calm = 1'b0;
		set_fingers(10'd15);
		write_reg(CFG_ID_BASE, 10'd1023);
		random_phase(55);
		settle();

		set_fingers(10'd0);
		random_phase(30);
		settle();

		sender_calm = 1'b1;
		set_fingers(10'd1);
		write_reg(CFG_ID_OFFSET_EN, 10'd0);
		write_reg(CFG_ID_BASE, 10'd0);
		random_phase(40);
		settle();

		sender_calm = 1'b0;
		set_fingers(10'd10);
		write_reg(CFG_ID_OFFSET_EN, 10'd1);
		random_phase(30);
		settle();

		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/trd_pkg.sv
rtl/core/trd_front.sv
rtl/core/trd_jobq.sv
rtl/core/trd_back.sv
rtl/core/touch_report_decoder.sv
tb/sv/touch_event_checker.sv
tb/sv/testbench.sv
